[src/tcw_pkg.sv]
// Shared constants for the text console writer.
package tcw_pkg;

	// Default matrix limits.
	localparam int DEF_MAX_COLUMNS = 80;
	localparam int DEF_MAX_ROWS    = 25;

	// Field and register widths.
	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;
	localparam int ATTR_W  = 8;
	localparam int CHAR_W  = 8;
	localparam int IDX_W   = 11;
	localparam int CELL_W  = 16;
	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;
	localparam int PROD_W  = 12;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_COLUMNS   = 2'd0;
	localparam logic [1:0] REG_ROWS      = 2'd1;
	localparam logic [1:0] REG_ATTRIBUTE = 2'd2;

	// Register reset values.
	localparam logic [COL_W-1:0]  RST_COLUMNS   = 7'd80;
	localparam logic [ROW_W-1:0]  RST_ROWS      = 5'd25;
	localparam logic [ATTR_W-1:0] RST_ATTRIBUTE = 8'd7;

	// Operation codes.
	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Character that moves the cursor to the next row.
	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

endpackage

[src/tcw_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/text_console_writer_unit.sv]
// Text console writer: top level with sequencer, cursor logic and cell memory.
//
// This block keeps a row-major matrix of 16-bit character cells (character in the
// low byte, attribute in the high byte) and a linear cursor. A put item writes its
// character with the configured attribute at the cursor and advances it; a newline
// moves the cursor to the start of the next row, scrolling the matrix up one row
// when the cursor is on the last row, and is dropped when the cursor sits at a row
// start right after a wrap onto a nonzero cell. A read item returns one cell. Every
// item yields exactly one result item. The block works on one item at a time and
// holds in_stall high until that item is finished, but it takes a new item while
// the previous result still waits in the output register. The cursor's row is
// found by stepping a shared adder one row at a time. A scroll copies the
// matrix through the single memory port pair and then clears the bottom row.
// After reset the block sweeps the cell memory to zero, one cell a cycle, and
// takes no item until all MAX_COLUMNS*MAX_ROWS cells (2000 by default) are
// cleared; configuration writes are taken during that sweep. Configuration
// registers (columns, rows, attribute) sit at byte addresses 0, 4 and 8 and
// must only be written while the block is idle. Column and row counts of zero
// act as one, and counts above the maximum act as the maximum.
module text_console_writer_unit
	import tcw_pkg::*;
#(
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
	input  logic                clk,
	input  logic                arst_n,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                operation,
	input  logic [CHAR_W-1:0]   char_code,
	input  logic [IDX_W-1:0]    cell_index,
	// output channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [CELL_W-1:0]   read_data,
	output logic [IDX_W-1:0]    cursor_position,
	output logic                did_scroll,
	output logic                newline_dropped,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready
);

	// Sizes that follow from the matrix limits. The cursor can never pass the
	// product of the largest column and row counts the registers can hold.
	localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
	localparam int AW         = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
	localparam int EFF_COLS   = (MAX_COLUMNS < 127) ? MAX_COLUMNS : 127;
	localparam int EFF_ROWS   = (MAX_ROWS < 31) ? MAX_ROWS : 31;
	localparam int CW         = $clog2(EFF_COLS * EFF_ROWS + 1);

	// Sequencer states.
	localparam logic [3:0] ST_INIT   = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_PREP   = 4'd2;
	localparam logic [3:0] ST_SAT    = 4'd3;
	localparam logic [3:0] ST_DIV    = 4'd4;
	localparam logic [3:0] ST_NLCHK  = 4'd5;
	localparam logic [3:0] ST_NLDEC  = 4'd6;
	localparam logic [3:0] ST_SCROLL = 4'd7;
	localparam logic [3:0] ST_CLEAR  = 4'd8;
	localparam logic [3:0] ST_WRCH   = 4'd9;
	localparam logic [3:0] ST_RDA    = 4'd10;
	localparam logic [3:0] ST_RDD    = 4'd11;
	localparam logic [3:0] ST_DONE   = 4'd12;

	logic [3:0]        state_q;

	// Configuration registers.
	logic [COL_W-1:0]  cols_q;
	logic [ROW_W-1:0]  rows_q;
	logic [ATTR_W-1:0] attr_q;

	// Item and working registers.
	logic              op_q;
	logic [CHAR_W-1:0] ch_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CW-1:0]     cur_q;
	logic [CW-1:0]     nc_q;
	logic [CW-1:0]     cmax_q;
	logic [CW-1:0]     acc_q;
	logic [CW-1:0]     src_q;
	logic [CW-1:0]     dst_q;
	logic [CW-1:0]     clr_q;
	logic              pend_q;
	logic [AW-1:0]     init_q;
	logic [CELL_W-1:0] rd_res_q;
	logic              scrolled_q;
	logic              dropped_q;

	// Output register.
	logic              out_valid_q;
	logic [CELL_W-1:0] read_data_q;
	logic [IDX_W-1:0]  cursor_position_q;
	logic              did_scroll_q;
	logic              newline_dropped_q;

	// Memory port signals.
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	logic in_accept;
	logic cfg_write;
	logic out_load;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	// Effective matrix size, clamped to the legal ranges.
	logic [COL_W-1:0]  nc_eff;
	logic [ROW_W-1:0]  nr_eff;
	logic [PROD_W-1:0] cmax_full;
	logic [CW+COL_W-1:0] nc_pad;

	always_comb begin
		if (cols_q == '0) begin
			nc_eff = COL_W'(1);
		end else if (int'(cols_q) > MAX_COLUMNS) begin
			nc_eff = COL_W'(MAX_COLUMNS);
		end else begin
			nc_eff = cols_q;
		end
		if (rows_q == '0) begin
			nr_eff = ROW_W'(1);
		end else if (int'(rows_q) > MAX_ROWS) begin
			nr_eff = ROW_W'(MAX_ROWS);
		end else begin
			nr_eff = rows_q;
		end
	end

	assign cmax_full = PROD_W'(nc_eff) * PROD_W'(nr_eff);
	assign nc_pad    = {{CW{1'b0}}, nc_eff};

	// Shared adder used for the row search and the newline target.
	logic [CW:0]   acc_nx;
	logic [CW-1:0] cur_sat;
	logic          row_start;

	assign acc_nx    = {1'b0, acc_q} + {1'b0, nc_q};
	assign cur_sat   = (cur_q > cmax_q) ? cmax_q : cur_q;
	assign row_start = (acc_q == cur_q) && (cur_q != '0);

	// Widening helpers so addresses work for any matrix limits.
	logic [CW+AW-1:0]    cur_apad;
	logic [CW+AW-1:0]    prev_apad;
	logic [CW+AW-1:0]    src_apad;
	logic [CW+AW-1:0]    dst_apad;
	logic [CW+AW-1:0]    clr_apad;
	logic [IDX_W+AW-1:0] idx_apad;
	logic [CW+IDX_W-1:0] cur_opad;
	logic [CW-1:0]       cur_dec;
	logic                idx_in_range;

	assign cur_dec      = cur_q - CW'(1);
	assign cur_apad     = {{AW{1'b0}}, cur_q};
	assign prev_apad    = {{AW{1'b0}}, cur_dec};
	assign src_apad     = {{AW{1'b0}}, src_q};
	assign dst_apad     = {{AW{1'b0}}, dst_q};
	assign clr_apad     = {{AW{1'b0}}, clr_q};
	assign idx_apad     = {{AW{1'b0}}, idx_q};
	assign cur_opad     = {{IDX_W{1'b0}}, cur_q};
	assign idx_in_range = (32'(idx_q) < CELL_COUNT);

	// Memory port selection by state.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_apad[AW-1:0];
		ram_wdata = {attr_q, ch_q};
		ram_raddr = idx_apad[AW-1:0];
		case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = init_q;
				ram_wdata = '0;
			end
			ST_DIV: begin
				ram_raddr = prev_apad[AW-1:0];
			end
			ST_SCROLL: begin
				ram_raddr = src_apad[AW-1:0];
				ram_we    = pend_q;
				ram_waddr = dst_apad[AW-1:0];
				ram_wdata = ram_rdata;
			end
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_apad[AW-1:0];
				ram_wdata = '0;
			end
			ST_WRCH: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	tcw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELL_COUNT)
	) u_cells (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Configuration registers and read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= RST_COLUMNS;
			rows_q <= RST_ROWS;
			attr_q <= RST_ATTRIBUTE;
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_COLUMNS:   cols_q <= pwdata[COL_W-1:0];
				REG_ROWS:      rows_q <= pwdata[ROW_W-1:0];
				REG_ATTRIBUTE: attr_q <= pwdata[ATTR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_COLUMNS:   prdata = APB_DW'(cols_q);
			REG_ROWS:      prdata = APB_DW'(rows_q);
			REG_ATTRIBUTE: prdata = APB_DW'(attr_q);
			default:       prdata = '0;
		endcase
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			init_q  <= '0;
			cur_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_INIT: begin
					if (init_q == AW'(CELL_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						init_q <= init_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= (operation == OP_READ) ? ST_RDA : ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					// A cursor left beyond the matrix by a register change is
					// pulled back to its end first.
					cur_q <= cur_sat;
					if (ch_q == NEWLINE_CODE) begin
						state_q <= ST_DIV;
					end else if (cur_sat == cmax_q) begin
						pend_q  <= 1'b0;
						state_q <= ST_SCROLL;
					end else begin
						state_q <= ST_WRCH;
					end
				end
				ST_DIV: begin
					// Step to the start of the cursor's row, one row a cycle.
					if (acc_nx <= {1'b0, cur_q}) begin
						state_q <= ST_DIV;
					end else if (row_start) begin
						state_q <= ST_NLCHK;
					end else begin
						state_q <= ST_NLDEC;
					end
				end
				ST_NLCHK: begin
					// A wrap onto a filled cell already moved the cursor down.
					state_q <= (ram_rdata != '0) ? ST_DONE : ST_NLDEC;
				end
				ST_NLDEC: begin
					if (acc_nx >= {1'b0, cmax_q}) begin
						pend_q  <= 1'b0;
						state_q <= ST_SCROLL;
					end else begin
						cur_q   <= acc_nx[CW-1:0];
						state_q <= ST_DONE;
					end
				end
				ST_SCROLL: begin
					// Reads run one cell ahead of the writes they feed.
					if (src_q < cmax_q) begin
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
						if (!pend_q) begin
							state_q <= ST_CLEAR;
						end
					end
				end
				ST_CLEAR: begin
					if (clr_q == cmax_q - CW'(1)) begin
						cur_q   <= cmax_q - nc_q;
						state_q <= (ch_q == NEWLINE_CODE) ? ST_DONE : ST_WRCH;
					end
				end
				ST_WRCH: begin
					cur_q   <= cur_q + CW'(1);
					state_q <= ST_DONE;
				end
				ST_RDA: begin
					state_q <= ST_RDD;
				end
				ST_RDD: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working data registers.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q       <= operation;
			ch_q       <= char_code;
			idx_q      <= cell_index;
			rd_res_q   <= '0;
			scrolled_q <= 1'b0;
			dropped_q  <= 1'b0;
		end
		case (state_q)
			ST_PREP: begin
				nc_q   <= nc_pad[CW-1:0];
				cmax_q <= cmax_full[CW-1:0];
			end
			ST_SAT: begin
				acc_q <= '0;
				if ((ch_q != NEWLINE_CODE) && (cur_sat == cmax_q)) begin
					src_q      <= nc_q;
					scrolled_q <= 1'b1;
				end
			end
			ST_DIV: begin
				if (acc_nx <= {1'b0, cur_q}) begin
					acc_q <= acc_nx[CW-1:0];
				end
			end
			ST_NLCHK: begin
				if (ram_rdata != '0) begin
					dropped_q <= 1'b1;
				end
			end
			ST_NLDEC: begin
				if (acc_nx >= {1'b0, cmax_q}) begin
					src_q      <= nc_q;
					scrolled_q <= 1'b1;
				end
			end
			ST_SCROLL: begin
				if (src_q < cmax_q) begin
					src_q <= src_q + CW'(1);
					dst_q <= src_q - nc_q;
				end
				clr_q <= cmax_q - nc_q;
			end
			ST_CLEAR: begin
				clr_q <= clr_q + CW'(1);
			end
			ST_RDD: begin
				rd_res_q <= idx_in_range ? ram_rdata : '0;
			end
			default: begin
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			read_data_q       <= rd_res_q;
			cursor_position_q <= cur_opad[IDX_W-1:0];
			did_scroll_q      <= scrolled_q;
			newline_dropped_q <= dropped_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign read_data       = read_data_q;
	assign cursor_position = cursor_position_q;
	assign did_scroll      = did_scroll_q;
	assign newline_dropped = newline_dropped_q;

	// A dropped newline changes nothing, so it never comes with a scroll.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(did_scroll_q && newline_dropped_q))
		else $error("scroll and dropped newline reported together");

	// After a put the cursor stays within the matrix.
	a_put_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && op_q == OP_PUT) |-> (cur_q <= cmax_q))
		else $error("cursor beyond matrix after a put");

	// A new result only ever comes out of the finishing state.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result loaded outside the finishing state");

	// The cell memory is never written while the block is idle.
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !ram_we)
		else $error("cell write while idle");

	// The bottom row is cleared only after the last copy write has landed.
	a_copy_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !pend_q)
		else $error("row clear overlaps a pending copy write");

endmodule
